[sv/slid_pkg.sv]
// slid_pkg: shared types, codes and sizes for the sorted key list
// no dependencies; every other file of the block but slid_enc refers to it by scoped names
`timescale 1ns / 1ps
`default_nettype none

package slid_pkg;

  // default number of key slots
  localparam int unsigned CAPACITY_DEF = 128;

  // fixed field widths of the item channels
  localparam int unsigned KEY_W    = 31;
  localparam int unsigned OPCODE_W = 1;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned TOTAL_W  = 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_DELETED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_ENC,
    S_UPD
  } state_e;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic del_en;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[sv/slid_in_if.sv]
// slid_in_if: valid/ready channel carrying one operation item
// depends on slid_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface slid_in_if;
  logic                         valid;
  logic                         ready;
  logic [slid_pkg::OPCODE_W-1:0] opcode;
  logic [slid_pkg::KEY_W-1:0]    key;

  modport source (output valid, output opcode, output key, input ready);
  modport sink   (input valid, input opcode, input key, output ready);
endinterface

`default_nettype wire

[sv/slid_out_if.sv]
// slid_out_if: valid/ready channel carrying one result item
// depends on slid_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface slid_out_if;
  logic                          valid;
  logic                          ready;
  logic [slid_pkg::STATUS_W-1:0] status;
  logic [slid_pkg::POS_W-1:0]    position;
  logic [slid_pkg::TOTAL_W-1:0]  entry_total;

  modport source (output valid, output status, output position, output entry_total,
                  input ready);
  modport sink   (input valid, input status, input position, input entry_total,
                  output ready);
endinterface

`default_nettype wire

[sv/slid_cell.sv]
// slid_cell: one slot of the sorted list, holds a key and its compare flags
// depends on slid_pkg; exchanges keys and flags with both neighbors
`timescale 1ns / 1ps
`default_nettype none

module slid_cell (
  input  wire logic                       clk_i,
  input  wire slid_pkg::cell_ctrl_t       ctrl_i,
  input  wire logic [slid_pkg::KEY_W-1:0] key_i,
  input  wire logic                       occ_i,
  input  wire logic [slid_pkg::KEY_W-1:0] left_key_i,
  input  wire logic                       left_lt_i,
  input  wire logic [slid_pkg::KEY_W-1:0] right_key_i,
  output logic [slid_pkg::KEY_W-1:0]      key_o,
  output logic                            lt_o,
  output logic                            bound_o,
  output logic                            hit_o
);

  logic [slid_pkg::KEY_W-1:0] key_q, key_d;
  logic                       lt_q, eq_q;

  // first cell not below the key is the insert point or delete candidate
  assign bound_o = !lt_q && left_lt_i;
  assign hit_o   = bound_o && eq_q;
  assign key_o   = key_q;
  assign lt_o    = lt_q;

  // parallel compare against the broadcast key
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmp_en) begin
      lt_q <= occ_i && (key_q < key_i);
      eq_q <= occ_i && (key_q == key_i);
    end
  end

  // shift up on insert, shift down on delete, cells below the point hold
  always_comb begin
    key_d = key_q;
    if (ctrl_i.ins_en && !lt_q) begin
      key_d = bound_o ? key_i : left_key_i;
    end else if (ctrl_i.del_en && !lt_q) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

`default_nettype wire

[sv/slid_enc.sv]
// slid_enc: turns the one-hot boundary of the cell row into an index
// and reduces the per-cell match flags; depends on nothing but its parameters
`timescale 1ns / 1ps
`default_nettype none

module slid_enc #(
  parameter int unsigned N     = 128,
  parameter int unsigned IDX_W = 7
) (
  input  wire logic [N-1:0]     bound_i,
  input  wire logic [N-1:0]     hit_i,
  output logic [IDX_W-1:0]      idx_o,
  output logic                  found_o
);

  // or-tree encode, the boundary is at most one cell
  always_comb begin
    idx_o = '0;
    for (int unsigned i = 0; i < N; i++) begin
      if (bound_i[i]) begin
        idx_o = idx_o | IDX_W'(i);
      end
    end
  end

  assign found_o = |hit_i;

endmodule

`default_nettype wire

[sv/sorted_list_insert_delete.sv]
// Sorted key list with insert and delete, built as a row of key cells.
// Depends on slid_pkg, slid_in_if, slid_out_if, slid_cell and slid_enc.
//
// Input channel in_if: opcode (0 insert, 1 delete) and a 31-bit key.
// Output channel out_if: status, position and entry_total, one result item
// for every input item, in order.
// An insert places the key ahead of equal keys and moves equal and larger
// keys up one cell; a full list refuses it. A delete removes the first equal
// key and moves the keys above it down; an absent key answers not found.
// Sequence: an accepted item passes the compare, encode and update steps
// before the next acceptance. Compare checks the key in every cell at once,
// encode turns the boundary cell into a position through an or-tree, update
// shifts the cells and loads the result register. in_if.ready is high only
// while the sequencer is idle.
// The output register lets a new item be accepted while a result waits;
// if the receiver stalls, that item holds in its last step, without
// touching the cells, until the output register is free.
// Reset empties the list (count zero) at once; no clearing pass is needed,
// cells above the count are never read.
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_insert_delete #(
  parameter int unsigned CAPACITY = slid_pkg::CAPACITY_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  slid_in_if.sink     in_if,
  slid_out_if.source  out_if
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);

  slid_pkg::state_e              state_q, state_d;
  slid_pkg::op_e                 op_q;
  logic [slid_pkg::KEY_W-1:0]    key_q;
  logic [CNT_W-1:0]              count_q, count_d;
  logic [IDX_W-1:0]              pos_q, pos_d;
  logic                          found_q, found_d;
  logic                          out_valid_q, out_valid_d;
  slid_pkg::status_e             status_q, status_d;
  logic [slid_pkg::POS_W-1:0]    position_q, position_d;
  logic [slid_pkg::TOTAL_W-1:0]  total_q, total_d;

  slid_pkg::cell_ctrl_t          ctrl;
  logic                          accept;
  logic                          commit;
  logic                          full;

  logic [slid_pkg::KEY_W-1:0]    cell_key [CAPACITY];
  logic [CAPACITY-1:0]           cell_lt;
  logic [CAPACITY-1:0]           cell_bound;
  logic [CAPACITY-1:0]           cell_hit;

  assign accept = in_if.valid && in_if.ready;
  assign commit = (state_q == slid_pkg::S_UPD) && (!out_valid_q || out_if.ready);
  assign full   = (count_q == CNT_W'(CAPACITY));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      slid_pkg::S_IDLE: begin
        if (accept) state_d = slid_pkg::S_CMP;
      end
      slid_pkg::S_CMP: state_d = slid_pkg::S_ENC;
      slid_pkg::S_ENC: state_d = slid_pkg::S_UPD;
      slid_pkg::S_UPD: begin
        if (commit) state_d = slid_pkg::S_IDLE;
      end
      default: state_d = slid_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_if.ready = 1'b0;
    ctrl        = '0;
    case (state_q)
      slid_pkg::S_IDLE: in_if.ready = 1'b1;
      slid_pkg::S_CMP:  ctrl.cmp_en = 1'b1;
      slid_pkg::S_ENC:  ctrl = '0;
      slid_pkg::S_UPD: begin
        ctrl.ins_en = commit && (op_q == slid_pkg::OP_INSERT) && !full;
        ctrl.del_en = commit && (op_q == slid_pkg::OP_DELETE) && found_q;
      end
      default: ctrl = '0;
    endcase
  end

  // row of cells, each trading keys and flags with its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                       occ;
    logic [slid_pkg::KEY_W-1:0] left_key;
    logic                       left_lt;
    logic [slid_pkg::KEY_W-1:0] right_key;

    assign occ = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_first
      assign left_key = key_q;
      assign left_lt  = 1'b1;
    end else begin : g_inner
      assign left_key = cell_key[i-1];
      assign left_lt  = cell_lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key = cell_key[i];
    end else begin : g_body
      assign right_key = cell_key[i+1];
    end

    slid_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .key_i       (key_q),
      .occ_i       (occ),
      .left_key_i  (left_key),
      .left_lt_i   (left_lt),
      .right_key_i (right_key),
      .key_o       (cell_key[i]),
      .lt_o        (cell_lt[i]),
      .bound_o     (cell_bound[i]),
      .hit_o       (cell_hit[i])
    );
  end

  // boundary position and match reduction
  slid_enc #(
    .N     (CAPACITY),
    .IDX_W (IDX_W)
  ) u_enc (
    .bound_i (cell_bound),
    .hit_i   (cell_hit),
    .idx_o   (pos_d),
    .found_o (found_d)
  );

  // result and count update
  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_if.ready;
    status_d    = status_q;
    position_d  = position_q;
    total_d     = total_q;
    if (commit) begin
      out_valid_d = 1'b1;
      position_d  = '0;
      if (op_q == slid_pkg::OP_INSERT) begin
        if (full) begin
          status_d = slid_pkg::ST_FULL;
        end else begin
          status_d   = slid_pkg::ST_INSERTED;
          position_d = slid_pkg::POS_W'(pos_q);
          count_d    = count_q + CNT_W'(1);
        end
      end else begin
        if (found_q) begin
          status_d   = slid_pkg::ST_DELETED;
          position_d = slid_pkg::POS_W'(pos_q);
          count_d    = count_q - CNT_W'(1);
        end else begin
          status_d = slid_pkg::ST_NOT_FOUND;
        end
      end
      total_d = slid_pkg::TOTAL_W'(count_d);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slid_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= slid_pkg::op_e'(in_if.opcode);
      key_q <= in_if.key;
    end
    if (state_q == slid_pkg::S_ENC) begin
      pos_q   <= pos_d;
      found_q <= found_d;
    end
    status_q   <= status_d;
    position_q <= position_d;
    total_q    <= total_d;
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.status      = status_q;
  assign out_if.position    = position_q;
  assign out_if.entry_total = total_q;

endmodule

`default_nettype wire

[sv/slid_chk.sv]
// slid_chk: port-level checks on the sorted key list over time
// depends on slid_pkg; bound to sorted_list_insert_delete at the end of this file
`timescale 1ns / 1ps
`default_nettype none

module slid_chk #(
  parameter int unsigned CAPACITY = slid_pkg::CAPACITY_DEF
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_i,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic [slid_pkg::STATUS_W-1:0] status_i,
  input wire logic [slid_pkg::POS_W-1:0]    position_i,
  input wire logic [slid_pkg::TOTAL_W-1:0]  total_i
);

  // a stalled result item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i)
      && $stable(position_i) && $stable(total_i))
    else $error("stalled result item changed");

  // one item at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while busy");

  // refused and absent results carry position zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == slid_pkg::ST_FULL || status_i == slid_pkg::ST_NOT_FOUND)
      |-> position_i == '0)
    else $error("nonzero position on refused item");

  // a refused insert reports a full list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == slid_pkg::ST_FULL
      |-> total_i == slid_pkg::TOTAL_W'(CAPACITY))
    else $error("full status without full count");

  // a delete never leaves the list full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == slid_pkg::ST_DELETED
      |-> total_i != slid_pkg::TOTAL_W'(CAPACITY) || CAPACITY >= (1 << slid_pkg::TOTAL_W))
    else $error("delete reported a full list");

endmodule

bind sorted_list_insert_delete slid_chk #(
  .CAPACITY (CAPACITY)
) u_slid_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .status_i    (out_if.status),
  .position_i  (out_if.position),
  .total_i     (out_if.entry_total)
);

`default_nettype wire
